>>> rtl/slst_pkg.sv
// Shared types and constants for the sorted list engine.
// No dependencies; imported by the controller, the datapath and the top level.
package slst_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = CNT_W + 1;

    typedef enum logic [1:0] {
        MODE_INSERT   = 2'd0,
        MODE_REMOVE   = 2'd1,
        MODE_CONTAINS = 2'd2,
        MODE_READ     = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_SCAN,
        S_INS_PUT,
        S_REM_SHIFT,
        S_CON_SCAN,
        S_RD_WAIT,
        S_FINISH
    } t_state;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_SET_TOP,
        IDX_SET_POS,
        IDX_SET_ZERO,
        IDX_DEC,
        IDX_INC
    } t_idx_op;

    typedef enum logic {
        WR_DATA,
        WR_VALUE
    } t_wr_src;

    typedef enum logic [1:0] {
        AT_IDX,
        AT_NEXT,
        AT_ZERO
    } t_wr_at;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        t_idx_op idx_op;
        logic    wr_en;
        t_wr_src wr_src;
        t_wr_at  wr_at;
        t_cnt_op cnt_op;
        logic    set_status;
        t_status status;
        logic    set_found;
        logic    set_rd_data;
        logic    set_rd_min;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_mode mode;
        logic  full;
        logic  empty;
        logic  pos_oor;
        logic  pos_last;
        logic  greater;
        logic  idx_zero;
        logic  rem_last;
        logic  equal;
        logic  con_last;
    } t_stat;

endpackage

>>> rtl/slst_ctrl.sv
// Sequencing state machine of the sorted list engine.
// Depends on slst_pkg; drives the datapath through t_cmd and reads t_stat.
module slst_ctrl import slst_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_valid
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                unique case (i_stat.mode)
                    MODE_INSERT: begin
                        if (i_stat.full)       n_state = S_FINISH;
                        else if (i_stat.empty) n_state = S_INS_PUT;
                        else                   n_state = S_INS_SCAN;
                    end
                    MODE_REMOVE: begin
                        if (i_stat.pos_oor || i_stat.pos_last) n_state = S_FINISH;
                        else                                   n_state = S_REM_SHIFT;
                    end
                    MODE_CONTAINS: begin
                        if (i_stat.empty) n_state = S_FINISH;
                        else              n_state = S_CON_SCAN;
                    end
                    MODE_READ: begin
                        if (i_stat.pos_oor) n_state = S_FINISH;
                        else                n_state = S_RD_WAIT;
                    end
                    default: n_state = S_FINISH;
                endcase
            end
            S_INS_SCAN: begin
                if (!i_stat.greater)      n_state = S_FINISH;
                else if (i_stat.idx_zero) n_state = S_INS_PUT;
            end
            S_INS_PUT:   n_state = S_FINISH;
            S_REM_SHIFT: begin
                if (i_stat.rem_last) n_state = S_FINISH;
            end
            S_CON_SCAN: begin
                if (i_stat.equal || i_stat.con_last) n_state = S_FINISH;
            end
            S_RD_WAIT:   n_state = S_FINISH;
            S_FINISH:    n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd            = '0;
        o_cmd.idx_op     = IDX_HOLD;
        o_cmd.wr_src     = WR_DATA;
        o_cmd.wr_at      = AT_IDX;
        o_cmd.cnt_op     = CNT_HOLD;
        o_cmd.status     = ST_OK;
        o_busy           = (r_state != S_IDLE);
        o_valid          = (r_state == S_FINISH);
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
            end
            S_DISPATCH: begin
                unique case (i_stat.mode)
                    MODE_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_FULL;
                        end else if (!i_stat.empty) begin
                            o_cmd.idx_op = IDX_SET_TOP;
                        end
                    end
                    MODE_REMOVE: begin
                        if (i_stat.pos_oor) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_RANGE;
                        end else if (i_stat.pos_last) begin
                            o_cmd.cnt_op = CNT_DEC;
                        end else begin
                            o_cmd.idx_op = IDX_SET_POS;
                        end
                    end
                    MODE_CONTAINS: begin
                        if (!i_stat.empty) o_cmd.idx_op = IDX_SET_ZERO;
                    end
                    MODE_READ: begin
                        if (i_stat.pos_oor) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_RANGE;
                            o_cmd.set_rd_min = 1'b1;
                        end else begin
                            o_cmd.idx_op = IDX_SET_POS;
                        end
                    end
                    default: ;
                endcase
            end
            S_INS_SCAN: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.wr_at = AT_NEXT;
                if (i_stat.greater) begin
                    o_cmd.wr_src = WR_DATA;
                    if (!i_stat.idx_zero) o_cmd.idx_op = IDX_DEC;
                end else begin
                    o_cmd.wr_src = WR_VALUE;
                    o_cmd.cnt_op = CNT_INC;
                end
            end
            S_INS_PUT: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_src = WR_VALUE;
                o_cmd.wr_at  = AT_ZERO;
                o_cmd.cnt_op = CNT_INC;
            end
            S_REM_SHIFT: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_src = WR_DATA;
                o_cmd.wr_at  = AT_IDX;
                if (i_stat.rem_last) o_cmd.cnt_op = CNT_DEC;
                else                 o_cmd.idx_op = IDX_INC;
            end
            S_CON_SCAN: begin
                if (i_stat.equal)          o_cmd.set_found = 1'b1;
                else if (!i_stat.con_last) o_cmd.idx_op    = IDX_INC;
            end
            S_RD_WAIT: begin
                o_cmd.set_rd_data = 1'b1;
            end
            S_FINISH: ;
            default: ;
        endcase
    end

endmodule

>>> rtl/slst_datapath.sv
// Entry store, item latch, scan index, entry count and result registers.
// Depends on slst_pkg; steered by slst_ctrl through t_cmd, reports t_stat.
module slst_datapath import slst_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_value,
    input  logic [4:0]         i_position,
    output t_stat              o_stat,
    output logic               o_found,
    output logic signed [31:0] o_read_value,
    output logic [4:0]         o_count,
    output logic [1:0]         o_status
);

    logic signed [31:0] r_mem [CAPACITY];
    logic signed [31:0] r_rdata;

    t_mode              r_mode;
    logic signed [31:0] r_value;
    logic [4:0]         r_pos;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_count, n_count;

    logic               r_found;
    logic signed [31:0] r_rd;
    t_status            r_status;

    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic signed [31:0] wr_data;

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= t_mode'(i_mode);
            r_value <= i_value;
            r_pos   <= i_position;
        end
    end

    // scan index
    always_comb begin
        n_idx = r_idx;
        case (i_cmd.idx_op)
            IDX_SET_TOP:  n_idx = IDX_W'(r_count - CNT_W'(1));
            IDX_SET_POS:  n_idx = IDX_W'(r_pos);
            IDX_SET_ZERO: n_idx = '0;
            IDX_DEC:      n_idx = r_idx - IDX_W'(1);
            IDX_INC:      n_idx = r_idx + IDX_W'(1);
            default:      n_idx = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
    end

    // removal reads one entry ahead of the slot it fills
    assign rd_addr = (r_mode == MODE_REMOVE) ? n_idx + IDX_W'(1) : n_idx;

    always_comb begin
        case (i_cmd.wr_at)
            AT_NEXT: wr_addr = r_idx + IDX_W'(1);
            AT_ZERO: wr_addr = '0;
            default: wr_addr = r_idx;
        endcase
    end

    assign wr_data = (i_cmd.wr_src == WR_VALUE) ? r_value : r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) r_mem[wr_addr] <= wr_data;
        r_rdata <= r_mem[rd_addr];
    end

    // entry count
    always_comb begin
        n_count = r_count;
        case (i_cmd.cnt_op)
            CNT_INC: n_count = r_count + CNT_W'(1);
            CNT_DEC: n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_found  <= 1'b0;
            r_rd     <= '0;
            r_status <= ST_OK;
        end else begin
            if (i_cmd.set_found)   r_found  <= 1'b1;
            if (i_cmd.set_rd_data) r_rd     <= r_rdata;
            if (i_cmd.set_rd_min)  r_rd     <= 32'sh8000_0000;
            if (i_cmd.set_status)  r_status <= i_cmd.status;
        end
    end

    // status to the controller
    always_comb begin
        o_stat.mode     = r_mode;
        o_stat.full     = (32'(r_count) >= 32'(CAPACITY));
        o_stat.empty    = (r_count == '0);
        o_stat.pos_oor  = (32'(r_pos) >= 32'(r_count));
        o_stat.pos_last = ((32'(r_pos) + 32'd1) == 32'(r_count));
        o_stat.greater  = (r_rdata > r_value);
        o_stat.idx_zero = (r_idx == '0);
        o_stat.rem_last = ((CMP_W'(r_idx) + CMP_W'(2)) == CMP_W'(r_count));
        o_stat.equal    = (r_rdata == r_value);
        o_stat.con_last = ((CMP_W'(r_idx) + CMP_W'(1)) == CMP_W'(r_count));
    end

    assign o_found      = r_found;
    assign o_read_value = r_rd;
    assign o_count      = 5'(r_count);
    assign o_status     = r_status;

endmodule

>>> rtl/sorted_list_engine.sv
// Sorted list engine: up to CAPACITY signed 32-bit values kept in ascending order.
// Operation length is set by one entry memory read and write per cycle: insert, remove and
//   contains scan entries, and rejected items go from dispatch straight to the strobe.
// Transactions: one at a time (busy through the strobe cycle, next accept in the cycle after);
//   the receiver cannot stall results.
// Reset (synchronous, active low) empties the list; entry contents are left as they are.
module sorted_list_engine import slst_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command side: accepted when start is high and busy is low
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_value,
    input  logic [4:0]         i_position,
    // result side: o_valid marks a one-cycle result, never held off
    output logic               o_valid,
    output logic               o_found,
    output logic signed [31:0] o_read_value,
    output logic [4:0]         o_count,
    output logic [1:0]         o_status
);

    t_cmd  cmd;
    t_stat stat;
    logic  ctrl_busy;

    // Controller: IDLE -> DISPATCH -> op-specific scan state(s) -> FINISH (strobe).
    slst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (ctrl_busy),
        .o_valid (o_valid)
    );

    // Datapath: entry memory with registered read, item latch, index and count.
    // Insert walks down from the top entry, moving larger entries up one slot,
    // and drops the new value in after the last entry not above it, so equal
    // values keep arrival order. Remove walks up from the index, closing the gap.
    slst_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_mode       (i_mode),
        .i_value      (i_value),
        .i_position   (i_position),
        .o_stat       (stat),
        .o_found      (o_found),
        .o_read_value (o_read_value),
        .o_count      (o_count),
        .o_status     (o_status)
    );

    assign busy = ctrl_busy;

endmodule
